// ===== hdl/nls_pkg.sv =====
package nls_pkg;

   localparam int unsigned DEF_MAX_LEN = 64;
   localparam int unsigned TOKEN_LEN_W = 7;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_F  = 8'h46;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_U     = 8'h55;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic KIND_INT   = 1'b0;
   localparam logic KIND_FLOAT = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ZERO     = 4'd1,
      PH_DEC_INT  = 4'd2,
      PH_DEC_FRAC = 4'd3,
      PH_DEC_EXP0 = 4'd4,
      PH_DEC_EXP  = 4'd5,
      PH_OCT_INT  = 4'd6,
      PH_OCT_FRAC = 4'd7,
      PH_OCT_EXP0 = 4'd8,
      PH_OCT_EXP  = 4'd9,
      PH_HEX_INT  = 4'd10,
      PH_HEX_FRAC = 4'd11,
      PH_HEX_EXP0 = 4'd12,
      PH_HEX_EXP  = 4'd13,
      PH_INT_DONE = 4'd14
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
   } req_item_type;

   typedef struct packed {
      logic                   token_kind;
      logic [TOKEN_LEN_W-1:0] token_length;
      logic                   too_long;
   } rsp_item_type;

endpackage

// ===== hdl/numeric_literal_scanner.sv =====
// an item taken into the input register goes through the phase step; one that
// ends a literal has its result registered on rsp until rsp_ready takes it
// throughput: one item per cycle unless a result meets a full rsp; an input
// register holds one item while a result waits, and the phase step is combinational
// reset: synchronous, active high; phase returns to idle, length and
// overflow clear, both item registers empty
module numeric_literal_scanner #(
   parameter int unsigned MAX_LEN = nls_pkg::DEF_MAX_LEN
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nls_pkg::req_item_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nls_pkg::rsp_item_type rsp_item
);

   localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
   localparam int unsigned TLW   = nls_pkg::TOKEN_LEN_W;

   logic                   in_valid_ff;
   nls_pkg::req_item_type  in_item_ff;
   logic                   rsp_valid_ff;
   nls_pkg::rsp_item_type  rsp_item_ff;

   nls_pkg::scan_phase_type phase_ff, phase_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    ovf_ff, ovf_in;

   logic                    emit;
   logic                    emit_kind;
   logic [LEN_W-1:0]        emit_len;
   logic                    emit_ovf;
   logic [LEN_W+TLW-1:0]    emit_len_ext;
   nls_pkg::scan_phase_type step_phase;
   logic                    proc_go;
   logic                    rsp_free;

   logic [7:0] c;
   logic       is_dec, is_oct, is_hex, is_sign;

   assign c       = in_item_ff.ch;
   assign is_dec  = (c >= nls_pkg::CH_ZERO) && (c <= nls_pkg::CH_NINE);
   assign is_oct  = (c >= nls_pkg::CH_ZERO) && (c <= nls_pkg::CH_SEVEN);
   assign is_hex  = is_dec || ((c >= nls_pkg::CH_UC_A) && (c <= nls_pkg::CH_UC_F));
   assign is_sign = (c == nls_pkg::CH_PLUS) || (c == nls_pkg::CH_MINUS);

   // per-character phase step, idle means the character ends the literal
   always_comb begin
      step_phase = nls_pkg::PH_IDLE;
      unique case (phase_ff)
         nls_pkg::PH_ZERO: begin
            if (c == nls_pkg::CH_UNDER)    step_phase = nls_pkg::PH_OCT_INT;
            else if (c == nls_pkg::CH_X)   step_phase = nls_pkg::PH_HEX_INT;
            else if (is_dec)               step_phase = nls_pkg::PH_DEC_INT;
            else if (c == nls_pkg::CH_DOT) step_phase = nls_pkg::PH_DEC_FRAC;
            else if (c == nls_pkg::CH_U)   step_phase = nls_pkg::PH_INT_DONE;
         end
         nls_pkg::PH_DEC_INT: begin
            if (is_dec)                    step_phase = nls_pkg::PH_DEC_INT;
            else if (c == nls_pkg::CH_DOT) step_phase = nls_pkg::PH_DEC_FRAC;
            else if (c == nls_pkg::CH_U)   step_phase = nls_pkg::PH_INT_DONE;
         end
         nls_pkg::PH_DEC_FRAC: begin
            if (is_dec)                    step_phase = nls_pkg::PH_DEC_FRAC;
            else if (c == nls_pkg::CH_E)   step_phase = nls_pkg::PH_DEC_EXP0;
         end
         nls_pkg::PH_DEC_EXP0: begin
            if (is_sign || is_dec)         step_phase = nls_pkg::PH_DEC_EXP;
         end
         nls_pkg::PH_DEC_EXP: begin
            if (is_dec)                    step_phase = nls_pkg::PH_DEC_EXP;
         end
         nls_pkg::PH_OCT_INT: begin
            if (is_oct)                    step_phase = nls_pkg::PH_OCT_INT;
            else if (c == nls_pkg::CH_DOT) step_phase = nls_pkg::PH_OCT_FRAC;
            else if (c == nls_pkg::CH_P)   step_phase = nls_pkg::PH_OCT_EXP0;
            else if (c == nls_pkg::CH_U)   step_phase = nls_pkg::PH_INT_DONE;
         end
         nls_pkg::PH_OCT_FRAC: begin
            if (is_oct)                    step_phase = nls_pkg::PH_OCT_FRAC;
            else if (c == nls_pkg::CH_P)   step_phase = nls_pkg::PH_OCT_EXP0;
         end
         nls_pkg::PH_OCT_EXP0: begin
            if (is_sign || is_oct)         step_phase = nls_pkg::PH_OCT_EXP;
         end
         nls_pkg::PH_OCT_EXP: begin
            if (is_oct)                    step_phase = nls_pkg::PH_OCT_EXP;
         end
         nls_pkg::PH_HEX_INT: begin
            if (is_hex)                    step_phase = nls_pkg::PH_HEX_INT;
            else if (c == nls_pkg::CH_DOT) step_phase = nls_pkg::PH_HEX_FRAC;
            else if (c == nls_pkg::CH_P)   step_phase = nls_pkg::PH_HEX_EXP0;
            else if (c == nls_pkg::CH_U)   step_phase = nls_pkg::PH_INT_DONE;
         end
         nls_pkg::PH_HEX_FRAC: begin
            if (is_hex)                    step_phase = nls_pkg::PH_HEX_FRAC;
            else if (c == nls_pkg::CH_P)   step_phase = nls_pkg::PH_HEX_EXP0;
         end
         nls_pkg::PH_HEX_EXP0: begin
            if (is_sign || is_hex)         step_phase = nls_pkg::PH_HEX_EXP;
         end
         nls_pkg::PH_HEX_EXP: begin
            if (is_hex)                    step_phase = nls_pkg::PH_HEX_EXP;
         end
         default: begin
            step_phase = nls_pkg::PH_IDLE;
         end
      endcase
   end

   // item handling, state update and result
   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      emit      = 1'b0;
      emit_kind = nls_pkg::KIND_INT;
      emit_len  = len_ff;
      emit_ovf  = ovf_ff;
      if (in_item_ff.start_req) begin
         len_in = '0;
         ovf_in = 1'b0;
         if (c == nls_pkg::CH_ZERO) begin
            phase_in = nls_pkg::PH_ZERO;
            len_in   = LEN_W'(1);
         end else if (is_dec) begin
            phase_in = nls_pkg::PH_DEC_INT;
            len_in   = LEN_W'(1);
         end else if (c == nls_pkg::CH_DOT) begin
            phase_in = nls_pkg::PH_DEC_FRAC;
            len_in   = LEN_W'(1);
         end else begin
            phase_in = nls_pkg::PH_IDLE;
            emit     = 1'b1;
            emit_len = '0;
            emit_ovf = 1'b0;
         end
      end else if (phase_ff == nls_pkg::PH_IDLE || phase_ff > nls_pkg::PH_INT_DONE) begin
         phase_in = nls_pkg::PH_IDLE;
      end else if (step_phase == nls_pkg::PH_IDLE) begin
         phase_in = nls_pkg::PH_IDLE;
         emit     = 1'b1;
         if (!(phase_ff == nls_pkg::PH_ZERO    || phase_ff == nls_pkg::PH_DEC_INT ||
               phase_ff == nls_pkg::PH_OCT_INT || phase_ff == nls_pkg::PH_HEX_INT ||
               phase_ff == nls_pkg::PH_INT_DONE)) begin
            emit_kind = nls_pkg::KIND_FLOAT;
         end
      end else begin
         phase_in = step_phase;
         if (len_ff >= LEN_W'(MAX_LEN)) begin
            len_in = LEN_W'(MAX_LEN);
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   assign emit_len_ext = {{TLW{1'b0}}, emit_len};
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign proc_go      = in_valid_ff && (rsp_free || !emit);
   assign req_ready    = !in_valid_ff || proc_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= nls_pkg::PH_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (proc_go) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            ovf_ff   <= ovf_in;
         end
         if (proc_go && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
      if (proc_go && emit) begin
         rsp_item_ff.token_kind   <= emit_kind;
         rsp_item_ff.token_length <= emit_len_ext[TLW-1:0];
         rsp_item_ff.too_long     <= emit_ovf;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
